FILE: hw/rtl/line_log_ring_buffer_macros.svh
// ----------------------------------------------------------------------------
// line log ring buffer assertion macros
// clocked property checks, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LINE_LOG_RING_BUFFER_MACROS_SVH
`define LINE_LOG_RING_BUFFER_MACROS_SVH

`ifndef SYNTH
`define LLRB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("llrb check failed");
`define LLRB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("llrb check failed");
`else
`define LLRB_ASSERT(lbl, clk, rstn, prop)
`define LLRB_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: hw/rtl/llrb_pkg.sv
// ----------------------------------------------------------------------------
// llrb_pkg
// shared types and constants of the line log ring buffer
// ----------------------------------------------------------------------------
package llrb_pkg;

    localparam int MODE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 8;
    localparam int OFS_W    = 12;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 56;
    localparam int BCAP_W   = 13;
    localparam int LCAP_W   = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 13;
    localparam int QDEPTH   = 2;

    localparam logic [MODE_W-1:0] MODE_STREAM   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MARK_BEG = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MARK_BYTE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MARK_END = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_CAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_CAP = 1'd1;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_COMMIT,
        OP_COMMIT_NE,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic [OFS_W-1:0]  ofs;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMMIT,
        ST_CHECK,
        ST_DROP_REQ,
        ST_DROP_APPLY,
        ST_COPY,
        ST_FINISH,
        ST_RD_TBL,
        ST_RD_DATA,
        ST_RD_BYTE,
        ST_RESULT
    } state_t;

endpackage

FILE: hw/rtl/llrb_front.sv
// ----------------------------------------------------------------------------
// llrb_front
// accepts input items and turns each into a command for the back end
// ----------------------------------------------------------------------------
module llrb_front (
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [llrb_pkg::IN_W-1:0]   s_axis_tdata,   // data_byte, line_index, byte_offset
    input  logic [llrb_pkg::MODE_W-1:0] s_axis_tuser,   // mode
    output logic                        push_valid,
    input  logic                        push_ready,
    output llrb_pkg::cmd_t              push_cmd
);

    logic [llrb_pkg::BYTE_W-1:0] data_b;

    assign data_b        = s_axis_tdata[7:0];
    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid;

    always_comb begin
        push_cmd.data = data_b;
        push_cmd.idx  = s_axis_tdata[15:8];
        push_cmd.ofs  = s_axis_tdata[27:16];
        case (s_axis_tuser)
            llrb_pkg::MODE_STREAM: begin
                if (data_b == llrb_pkg::CH_LF) begin
                    push_cmd.op = llrb_pkg::OP_COMMIT;
                end else if (data_b == llrb_pkg::CH_CR) begin
                    push_cmd.op = llrb_pkg::OP_NOP;
                end else begin
                    push_cmd.op = llrb_pkg::OP_ADD;
                end
            end
            llrb_pkg::MODE_MARK_BEG:  push_cmd.op = llrb_pkg::OP_COMMIT_NE;
            llrb_pkg::MODE_MARK_BYTE: push_cmd.op = llrb_pkg::OP_ADD;
            llrb_pkg::MODE_MARK_END:  push_cmd.op = llrb_pkg::OP_COMMIT;
            llrb_pkg::MODE_CLEAR:     push_cmd.op = llrb_pkg::OP_CLEAR;
            llrb_pkg::MODE_READ:      push_cmd.op = llrb_pkg::OP_READ;
            default:                  push_cmd.op = llrb_pkg::OP_NOP;
        endcase
    end

endmodule

FILE: hw/rtl/llrb_queue.sv
// ----------------------------------------------------------------------------
// llrb_queue
// two entry command queue between front and back end
// ----------------------------------------------------------------------------
module llrb_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  llrb_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output llrb_pkg::cmd_t pop_cmd
);

    llrb_pkg::cmd_t ent_reg [llrb_pkg::QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'(llrb_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_cmd    = ent_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/llrb_back.sv
// ----------------------------------------------------------------------------
// llrb_back
// executes commands: pending line, commit with drops, ring store and reads
// ----------------------------------------------------------------------------
`include "line_log_ring_buffer_macros.svh"

module llrb_back #(
    parameter int STORE_BYTES = 4096,
    parameter int LINE_SLOTS  = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [$clog2(STORE_BYTES+1)-1:0]     cap_bytes,
    input  logic [$clog2(LINE_SLOTS+1)-1:0]      cap_lines,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  llrb_pkg::cmd_t                       pop_cmd,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [llrb_pkg::OUT_W-1:0]           m_axis_tdata
);

    localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CW  = $clog2(STORE_BYTES + 1);
    localparam int SW  = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
    localparam int HW  = $clog2(LINE_SLOTS + 1);
    localparam int IXW = ((SW > llrb_pkg::IDX_W) ? SW : llrb_pkg::IDX_W) + 1;
    localparam int OXW = ((AW > llrb_pkg::OFS_W) ? AW : llrb_pkg::OFS_W) + 1;

    llrb_pkg::state_t state_reg, state_next;
    llrb_pkg::cmd_t   cmd_reg, cmd_next;

    logic [CW-1:0] pend_len_reg, pend_len_next;
    logic [CW-1:0] len_reg, len_next;
    logic [HW-1:0] held_reg, held_next;
    logic [SW-1:0] oldest_reg, oldest_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] used_reg, used_next;
    logic [HW-1:0] drops_reg, drops_next;
    logic          disc_reg, disc_next;
    logic [7:0]    rbyte_reg, rbyte_next;
    logic [AW-1:0] rlen_reg, rlen_next;
    logic          rvalid_reg, rvalid_next;
    logic [CW-1:0] copy_k_reg, copy_k_next;
    logic [AW-1:0] copy_wa_reg, copy_wa_next;
    logic          cp_v_reg;
    logic [AW-1:0] cp_a_reg;
    logic          out_valid_reg, out_valid_next;
    logic [llrb_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    // memories
    logic [7:0]      pend_mem  [STORE_BYTES];
    logic [7:0]      store_mem [STORE_BYTES];
    logic [2*AW-1:0] tbl_mem   [LINE_SLOTS];
    logic [7:0]      pend_rdata, store_rdata;
    logic [2*AW-1:0] tbl_rdata;
    logic [AW-1:0]   tbl_off, tbl_len;

    logic            pend_we, pend_re, tbl_we, tbl_re, store_re;
    logic [AW-1:0]   pend_waddr, pend_raddr, store_raddr;
    logic [SW-1:0]   tbl_waddr, tbl_raddr;
    logic [2*AW-1:0] tbl_wdata;

    // shared conditions
    logic [CW:0]   need;
    logic [CW+1:0] used_plus;
    logic          over_cap, cap_full, fit_fail, copy_more, rd_hit, rd_in_line, out_free;
    logic [CW:0]   cost;
    logic [SW-1:0] new_slot, rd_slot, oldest_inc;
    logic [SW:0]   new_slot_sum;
    logic [IXW-1:0] rd_slot_sum;
    logic [OXW-1:0] byte_sum;
    logic [CW+1:0]  wp_sum;
    logic [AW-1:0]  wp_after, copy_wa_inc;

    assign tbl_off   = tbl_rdata[2*AW-1:AW];
    assign tbl_len   = tbl_rdata[AW-1:0];
    assign need      = (CW+1)'(len_reg) + (CW+1)'(1);
    assign used_plus = (CW+2)'(used_reg) + (CW+2)'(need);
    assign over_cap  = (need > (CW+1)'(cap_bytes));
    assign cap_full  = (held_reg >= cap_lines);
    assign fit_fail  = (held_reg != '0) && (used_plus > (CW+2)'(cap_bytes));
    assign copy_more = (copy_k_reg < len_reg);
    assign rd_hit    = (32'(cmd_reg.idx) < 32'(held_reg));
    assign rd_in_line = (32'(cmd_reg.ofs) < 32'(tbl_len));
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cost      = (CW+1)'(tbl_len) + (CW+1)'(1);

    assign oldest_inc = ((SW+1)'(oldest_reg) + (SW+1)'(1) >= (SW+1)'(LINE_SLOTS))
                        ? '0 : SW'(oldest_reg + SW'(1));
    assign new_slot_sum = (SW+1)'(oldest_reg) + (SW+1)'(held_reg);
    assign new_slot     = (new_slot_sum >= (SW+1)'(LINE_SLOTS))
                          ? SW'(new_slot_sum - (SW+1)'(LINE_SLOTS)) : SW'(new_slot_sum);
    assign rd_slot_sum  = IXW'(oldest_reg) + IXW'(cmd_reg.idx);
    assign rd_slot      = (rd_slot_sum >= IXW'(LINE_SLOTS))
                          ? SW'(rd_slot_sum - IXW'(LINE_SLOTS)) : SW'(rd_slot_sum);
    assign byte_sum     = OXW'(tbl_off) + OXW'(cmd_reg.ofs);
    assign wp_sum       = (CW+2)'(wp_reg) + (CW+2)'(need);
    assign wp_after     = (wp_sum >= (CW+2)'(STORE_BYTES))
                          ? AW'(wp_sum - (CW+2)'(STORE_BYTES)) : AW'(wp_sum);
    assign copy_wa_inc  = ((AW+1)'(copy_wa_reg) + (AW+1)'(1) >= (AW+1)'(STORE_BYTES))
                          ? '0 : AW'(copy_wa_reg + AW'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            llrb_pkg::ST_IDLE: begin
                if (pop_valid) begin
                    case (pop_cmd.op)
                        llrb_pkg::OP_COMMIT: state_next = llrb_pkg::ST_COMMIT;
                        llrb_pkg::OP_COMMIT_NE: begin
                            state_next = (pend_len_reg != '0) ? llrb_pkg::ST_COMMIT
                                                              : llrb_pkg::ST_RESULT;
                        end
                        llrb_pkg::OP_READ: state_next = llrb_pkg::ST_RD_TBL;
                        default:           state_next = llrb_pkg::ST_RESULT;
                    endcase
                end
            end
            llrb_pkg::ST_COMMIT: begin
                if (over_cap) begin
                    state_next = llrb_pkg::ST_RESULT;
                end else if (cap_full) begin
                    state_next = llrb_pkg::ST_DROP_REQ;
                end else begin
                    state_next = llrb_pkg::ST_CHECK;
                end
            end
            llrb_pkg::ST_CHECK: begin
                state_next = fit_fail ? llrb_pkg::ST_DROP_REQ : llrb_pkg::ST_COPY;
            end
            llrb_pkg::ST_DROP_REQ:   state_next = llrb_pkg::ST_DROP_APPLY;
            llrb_pkg::ST_DROP_APPLY: state_next = llrb_pkg::ST_CHECK;
            llrb_pkg::ST_COPY: begin
                if (!copy_more) begin
                    state_next = llrb_pkg::ST_FINISH;
                end
            end
            llrb_pkg::ST_FINISH: state_next = llrb_pkg::ST_RESULT;
            llrb_pkg::ST_RD_TBL: begin
                state_next = rd_hit ? llrb_pkg::ST_RD_DATA : llrb_pkg::ST_RESULT;
            end
            llrb_pkg::ST_RD_DATA: begin
                state_next = rd_in_line ? llrb_pkg::ST_RD_BYTE : llrb_pkg::ST_RESULT;
            end
            llrb_pkg::ST_RD_BYTE: state_next = llrb_pkg::ST_RESULT;
            llrb_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = llrb_pkg::ST_IDLE;
                end
            end
            default: state_next = llrb_pkg::ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        pop_ready   = (state_reg == llrb_pkg::ST_IDLE);
        pend_we     = (state_reg == llrb_pkg::ST_IDLE) && pop_valid
                      && (pop_cmd.op == llrb_pkg::OP_ADD) && (pend_len_reg < cap_bytes);
        pend_waddr  = AW'(pend_len_reg);
        pend_re     = (state_reg == llrb_pkg::ST_COPY) && copy_more;
        pend_raddr  = AW'(copy_k_reg);
        tbl_we      = (state_reg == llrb_pkg::ST_FINISH);
        tbl_waddr   = new_slot;
        tbl_wdata   = {wp_reg, AW'(len_reg)};
        tbl_re      = (state_reg == llrb_pkg::ST_DROP_REQ)
                      || ((state_reg == llrb_pkg::ST_RD_TBL) && rd_hit);
        tbl_raddr   = (state_reg == llrb_pkg::ST_DROP_REQ) ? oldest_reg : rd_slot;
        store_re    = (state_reg == llrb_pkg::ST_RD_DATA) && rd_in_line;
        store_raddr = (byte_sum >= OXW'(STORE_BYTES))
                      ? AW'(byte_sum - OXW'(STORE_BYTES)) : AW'(byte_sum);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = out_data_reg;
    end

    // datapath
    always_comb begin
        cmd_next      = cmd_reg;
        pend_len_next = pend_len_reg;
        len_next      = len_reg;
        held_next     = held_reg;
        oldest_next   = oldest_reg;
        wp_next       = wp_reg;
        used_next     = used_reg;
        drops_next    = drops_reg;
        disc_next     = disc_reg;
        rbyte_next    = rbyte_reg;
        rlen_next     = rlen_reg;
        rvalid_next   = rvalid_reg;
        copy_k_next   = copy_k_reg;
        copy_wa_next  = copy_wa_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            llrb_pkg::ST_IDLE: begin
                if (pop_valid) begin
                    cmd_next    = pop_cmd;
                    len_next    = pend_len_reg;
                    drops_next  = '0;
                    disc_next   = 1'b0;
                    rbyte_next  = '0;
                    rlen_next   = '0;
                    rvalid_next = 1'b0;
                    if (pend_we) begin
                        pend_len_next = pend_len_reg + CW'(1);
                    end
                    if (pop_cmd.op == llrb_pkg::OP_CLEAR) begin
                        oldest_next   = '0;
                        held_next     = '0;
                        wp_next       = '0;
                        used_next     = '0;
                        pend_len_next = '0;
                    end
                end
            end
            llrb_pkg::ST_COMMIT: begin
                pend_len_next = '0;
                disc_next     = over_cap;
            end
            llrb_pkg::ST_CHECK: begin
                copy_k_next  = '0;
                copy_wa_next = wp_reg;
                if (!fit_fail && (held_reg == '0)) begin
                    used_next = '0;
                end
            end
            llrb_pkg::ST_DROP_APPLY: begin
                used_next   = ((CW+1)'(used_reg) >= cost) ? CW'((CW+1)'(used_reg) - cost) : '0;
                oldest_next = oldest_inc;
                held_next   = held_reg - HW'(1);
                drops_next  = drops_reg + HW'(1);
            end
            llrb_pkg::ST_COPY: begin
                if (copy_more) begin
                    copy_k_next  = copy_k_reg + CW'(1);
                    copy_wa_next = copy_wa_inc;
                end
            end
            llrb_pkg::ST_FINISH: begin
                wp_next   = wp_after;
                used_next = CW'(used_plus);
                held_next = held_reg + HW'(1);
            end
            llrb_pkg::ST_RD_DATA: begin
                rvalid_next = 1'b1;
                rlen_next   = tbl_len;
            end
            llrb_pkg::ST_RD_BYTE: begin
                rbyte_next = store_rdata;
            end
            llrb_pkg::ST_RESULT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'd0, disc_reg, 9'(drops_reg), 13'(used_reg),
                                      9'(held_reg), rvalid_reg, 12'(rlen_reg), rbyte_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= llrb_pkg::ST_IDLE;
            pend_len_reg  <= '0;
            held_reg      <= '0;
            oldest_reg    <= '0;
            wp_reg        <= '0;
            used_reg      <= '0;
            cp_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_len_reg  <= pend_len_next;
            held_reg      <= held_next;
            oldest_reg    <= oldest_next;
            wp_reg        <= wp_next;
            used_reg      <= used_next;
            cp_v_reg      <= pend_re;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        len_reg      <= len_next;
        drops_reg    <= drops_next;
        disc_reg     <= disc_next;
        rbyte_reg    <= rbyte_next;
        rlen_reg     <= rlen_next;
        rvalid_reg   <= rvalid_next;
        copy_k_reg   <= copy_k_next;
        copy_wa_reg  <= copy_wa_next;
        cp_a_reg     <= copy_wa_reg;
        out_data_reg <= out_data_next;
    end

    // pending line
    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[pend_waddr] <= pop_cmd.data;
        end
        if (pend_re) begin
            pend_rdata <= pend_mem[pend_raddr];
        end
    end

    // ring byte store, written in the cycle after the pending read
    always_ff @(posedge aclk) begin
        if (cp_v_reg) begin
            store_mem[cp_a_reg] <= pend_rdata;
        end
        if (store_re) begin
            store_rdata <= store_mem[store_raddr];
        end
    end

    // line descriptor ring
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            tbl_rdata <= tbl_mem[tbl_raddr];
        end
    end

    `LLRB_ASSERT(a_held_bound, aclk, aresetn, 32'(held_reg) <= LINE_SLOTS)
    `LLRB_ASSERT(a_used_bound, aclk, aresetn, 32'(used_reg) <= STORE_BYTES)
    `LLRB_ASSERT_IMPL(a_copy_src, aclk, aresetn, cp_v_reg, $past(state_reg) == llrb_pkg::ST_COPY)
    `LLRB_ASSERT_IMPL(a_out_load, aclk, aresetn, $rose(out_valid_reg),
                      $past(state_reg) == llrb_pkg::ST_RESULT)

endmodule

FILE: hw/rtl/line_log_ring_buffer.sv
// ----------------------------------------------------------------------------
// line_log_ring_buffer
// text line log held in a circular byte store with a ring of line descriptors
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per transfer: tuser is the mode (stream byte,
//   mark start, mark byte, mark end, clear, read), tdata the byte, the line
//   index and the byte offset. every item gives exactly one result on m_axis
//   with the read byte, line length, index valid flag and the status counts.
//   cfg_* writes byte_capacity (index 0) and line_capacity (index 1); write
//   only while the block is idle. ready is always high on that port.
// operation (back end idle, receiver ready):
//   a byte, clear or no-op item goes straight to its result, as does a
//   discarded overlong line; a read does a descriptor read, then a byte
//   store read, each registered. a kept commit may first drop the oldest
//   line for the line cap and then further lines for bytes, and then
//   the pending line is copied one byte a cycle through a single memory port.
//   the back end works one item at a time; a two entry queue lets the input
//   side accept while it is busy.
// reset:
//   aresetn clears line, byte and pending counts and pointers; the stores
//   need no clearing pass, and the capacity registers go back to 4096 bytes and 256 lines.
// stall:
//   when m_axis_tready is low the result is held in the output register, the
//   back end waits and the queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module line_log_ring_buffer #(
    parameter int STORE_BYTES = 4096,
    parameter int LINE_SLOTS  = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [llrb_pkg::IN_W-1:0]        s_axis_tdata,   // data_byte, line_index, byte_offset
    input  logic [llrb_pkg::MODE_W-1:0]      s_axis_tuser,   // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_byte, line_length, index_valid, line_count, bytes_used,
    // lines_dropped, line_discarded
    output logic [llrb_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [llrb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [llrb_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CW = $clog2(STORE_BYTES + 1);
    localparam int HW = $clog2(LINE_SLOTS + 1);

    // configuration registers, byte cap kept raw, line cap cut to 9 bits, both saturated on use
    logic [llrb_pkg::BCAP_W-1:0] bcap_reg, bcap_next;
    logic [llrb_pkg::LCAP_W-1:0] lcap_reg, lcap_next;
    logic [CW-1:0]               cap_bytes;
    logic [HW-1:0]               cap_lines;
    logic [31:0]                 bcap_w, lcap_w;

    // front to queue to back
    logic           push_valid, push_ready, pop_valid, pop_ready;
    llrb_pkg::cmd_t push_cmd, pop_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        bcap_next = bcap_reg;
        lcap_next = lcap_reg;
        if (cfg_valid) begin
            case (cfg_index)
                llrb_pkg::CFG_BYTE_CAP: bcap_next = cfg_data;
                llrb_pkg::CFG_LINE_CAP: lcap_next = llrb_pkg::LCAP_W'(cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcap_reg <= 13'd4096;
            lcap_reg <= 9'd256;
        end else begin
            bcap_reg <= bcap_next;
            lcap_reg <= lcap_next;
        end
    end

    // clamp to [2, STORE_BYTES] and [1, LINE_SLOTS]
    always_comb begin
        bcap_w = 32'(bcap_reg);
        lcap_w = 32'(lcap_reg);
        if (bcap_w < 32'd2) begin
            bcap_w = 32'd2;
        end else if (bcap_w > 32'(STORE_BYTES)) begin
            bcap_w = 32'(STORE_BYTES);
        end
        if (lcap_w < 32'd1) begin
            lcap_w = 32'd1;
        end else if (lcap_w > 32'(LINE_SLOTS)) begin
            lcap_w = 32'(LINE_SLOTS);
        end
        cap_bytes = CW'(bcap_w);
        cap_lines = HW'(lcap_w);
    end

    llrb_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    llrb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    llrb_back #(
        .STORE_BYTES (STORE_BYTES),
        .LINE_SLOTS  (LINE_SLOTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cap_bytes     (cap_bytes),
        .cap_lines     (cap_lines),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_cmd       (pop_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: sim/line_log_ring_buffer_tb.sv
// ----------------------------------------------------------------------------
// line_log_ring_buffer_tb
// self-checking bench: directed table then random line traffic over several
// capacity settings, each result compared against a behavioral line log
// or, for the typed directed rows, against a given expected value
module line_log_ring_buffer_tb;

    localparam logic [llrb_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [llrb_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;
    localparam int STORE_DEPTH = 4096;
    localparam int SLOT_DEPTH  = 256;
    localparam int PHASE_ITEMS = 220;
    localparam int NUM_PHASES  = 8;

    typedef struct {
        logic [7:0]  rd_byte;
        logic [11:0] length;
        logic        valid;
        logic [8:0]  count;
        logic [12:0] used;
        logic [8:0]  dropped;
        logic        discarded;
    } status_t;

    typedef struct {
        logic [llrb_pkg::MODE_W-1:0] mode;
        logic [7:0]                  data;
        logic [7:0]                  idx;
        logic [11:0]                 ofs;
        bit                          typed;   // expected value given below, not predicted
    } row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [llrb_pkg::IN_W-1:0]      s_axis_tdata = '0;
    logic [llrb_pkg::MODE_W-1:0]    s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [llrb_pkg::OUT_W-1:0]     m_axis_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [llrb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [llrb_pkg::CFG_W-1:0]     cfg_data = '0;

    line_log_ring_buffer dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the line log
    logic [7:0]  shadow_store [STORE_DEPTH];
    logic [7:0]  shadow_pend [STORE_DEPTH];
    int unsigned shadow_off [SLOT_DEPTH];
    int unsigned shadow_len [SLOT_DEPTH];
    int unsigned oldest, held, wr_ptr, used_bytes, pend_len;
    int unsigned cfg_byte_limit = 4096, line_cap = 256;
    int unsigned drops, discard;

    status_t     expected_status_q [$];
    int          fail_count = 0;
    int          send_pct = 0, recv_pct = 0;

    function automatic int unsigned eff_byte_cap();
        return (cfg_byte_limit < 2) ? 2 :
               (cfg_byte_limit > STORE_DEPTH) ? STORE_DEPTH : cfg_byte_limit;
    endfunction

    function automatic int unsigned eff_line_cap();
        return (line_cap < 1) ? 1 : (line_cap > SLOT_DEPTH) ? SLOT_DEPTH : line_cap;
    endfunction

    function automatic void drop_oldest_line();
        int unsigned cost;
        if (held == 0) return;
        cost = shadow_len[oldest] + 1;
        used_bytes = (used_bytes >= cost) ? used_bytes - cost : 0;
        oldest = (oldest + 1) % SLOT_DEPTH;
        held--;
        drops++;
    endfunction

    function automatic void append_pending(logic [7:0] b);
        if (pend_len < eff_byte_cap()) begin
            shadow_pend[pend_len] = b;
            pend_len++;
        end
    endfunction

    function automatic void flush_pending_line();
        int unsigned len, need, slot;
        len = pend_len;
        need = len + 1;
        pend_len = 0;
        // overlong line never enters the store
        if (need > eff_byte_cap()) begin
            discard = 1;
            return;
        end
        if (held >= eff_line_cap()) drop_oldest_line();
        while (held > 0 && used_bytes + need > eff_byte_cap()) drop_oldest_line();
        if (held == 0) used_bytes = 0;
        for (int unsigned k = 0; k < len; k++)
            shadow_store[(wr_ptr + k) % STORE_DEPTH] = shadow_pend[k];
        shadow_store[(wr_ptr + len) % STORE_DEPTH] = 8'h00;
        slot = (oldest + held) % SLOT_DEPTH;
        shadow_off[slot] = wr_ptr;
        shadow_len[slot] = len;
        wr_ptr = (wr_ptr + need) % STORE_DEPTH;
        used_bytes += need;
        held++;
    endfunction

    // advance the shadow log by one item, return the status it produces
    function automatic status_t log_step(logic [2:0] mode, logic [7:0] b,
                                         logic [7:0] idx, logic [11:0] ofs);
        status_t r;
        int unsigned slot;
        r = '{default: '0};
        drops = 0;
        discard = 0;
        case (mode)
            llrb_pkg::MODE_STREAM: begin
                if (b == llrb_pkg::CH_LF) flush_pending_line();
                else if (b != llrb_pkg::CH_CR) append_pending(b);
            end
            llrb_pkg::MODE_MARK_BEG: begin
                if (pend_len > 0) flush_pending_line();
            end
            llrb_pkg::MODE_MARK_BYTE: append_pending(b);
            llrb_pkg::MODE_MARK_END:  flush_pending_line();
            llrb_pkg::MODE_CLEAR: begin
                oldest = 0;
                held = 0;
                wr_ptr = 0;
                used_bytes = 0;
                pend_len = 0;
            end
            llrb_pkg::MODE_READ: begin
                if (idx < held) begin
                    slot = (oldest + idx) % SLOT_DEPTH;
                    r.valid = 1'b1;
                    r.length = 12'(shadow_len[slot]);
                    if (ofs < shadow_len[slot])
                        r.rd_byte = shadow_store[(shadow_off[slot] + ofs) % STORE_DEPTH];
                end
            end
            default: ;
        endcase
        r.count = 9'(held);
        r.used = 13'(used_bytes);
        r.dropped = 9'(drops);
        r.discarded = discard[0];
        return r;
    endfunction

    // one item on the input stream, gaps drawn from send_pct
    task automatic send_item(logic [2:0] mode, logic [7:0] b, logic [7:0] idx,
                             logic [11:0] ofs, bit typed, status_t typed_exp);
        status_t pred;
        while ($urandom_range(99) < send_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0, ofs, idx, b};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pred = log_step(mode, b, idx, ofs);
        expected_status_q.push_back(typed ? typed_exp : pred);
    endtask

    task automatic write_reg(logic [llrb_pkg::CFG_IDX_W-1:0] idx,
                             logic [llrb_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == llrb_pkg::CFG_BYTE_CAP) cfg_byte_limit = 32'(val);
        else line_cap = 32'(val[8:0]);
    endtask

    // block is idle only when every result is back, then a short settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_random_item();
        int unsigned pick, hi;
        logic [7:0]  b, idx;
        logic [11:0] ofs;
        logic [2:0]  mode;
        status_t     none;
        none = '{default: '0};
        pick = $urandom_range(99);
        b = 8'($urandom_range(255));
        // mostly text lines: stream bytes with newlines, some marker framing
        if (pick < 60) begin
            mode = llrb_pkg::MODE_STREAM;
            if ($urandom_range(99) < 9) b = llrb_pkg::CH_LF;
            else if ($urandom_range(99) < 3) b = llrb_pkg::CH_CR;
        end else if (pick < 67) mode = llrb_pkg::MODE_MARK_BEG;
        else if (pick < 75) mode = llrb_pkg::MODE_MARK_BYTE;
        else if (pick < 80) mode = llrb_pkg::MODE_MARK_END;
        else if (pick < 81) mode = llrb_pkg::MODE_CLEAR;
        else if (pick < 98) mode = llrb_pkg::MODE_READ;
        else mode = ($urandom_range(1)) ? MODE_SPARE6 : MODE_SPARE7;
        hi = (held + 1 > 255) ? 255 : held + 1;
        idx = 8'(($urandom_range(99) < 80) ? $urandom_range(hi) : $urandom_range(255));
        ofs = 12'(($urandom_range(99) < 75) ? $urandom_range(15) : $urandom_range(4095));
        send_item(mode, b, idx, ofs, 1'b0, none);
    endtask

    // result side: random stall, compare each accepted item with the oldest
    // expectation
    always @(posedge aclk) begin
        status_t e;
        logic [llrb_pkg::OUT_W-1:0] t;
        m_axis_tready <= ($urandom_range(99) >= recv_pct);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            t = m_axis_tdata;
            if (expected_status_q.size() == 0) begin
                $error("result with nothing expected: %h", t);
                fail_count++;
            end else begin
                e = expected_status_q.pop_front();
                if (t[7:0] !== e.rd_byte) begin
                    $error("read_byte exp %0d got %0d", e.rd_byte, t[7:0]);
                    fail_count++;
                end
                if (t[19:8] !== e.length) begin
                    $error("line_length exp %0d got %0d", e.length, t[19:8]);
                    fail_count++;
                end
                if (t[20] !== e.valid) begin
                    $error("index_valid exp %0d got %0d", e.valid, t[20]);
                    fail_count++;
                end
                if (t[29:21] !== e.count) begin
                    $error("line_count exp %0d got %0d", e.count, t[29:21]);
                    fail_count++;
                end
                if (t[42:30] !== e.used) begin
                    $error("bytes_used exp %0d got %0d", e.used, t[42:30]);
                    fail_count++;
                end
                if (t[51:43] !== e.dropped) begin
                    $error("lines_dropped exp %0d got %0d", e.dropped, t[51:43]);
                    fail_count++;
                end
                if (t[52] !== e.discarded) begin
                    $error("line_discarded exp %0d got %0d", e.discarded, t[52]);
                    fail_count++;
                end
            end
        end
    end

    // directed rows: reset state, cr drop, marker framing, spare modes, clear
    row_t rows [24] = '{
        '{llrb_pkg::MODE_READ,      8'h00,           8'd0,   12'd0,    1'b1},  // empty log
        '{llrb_pkg::MODE_STREAM,    8'h61,           8'd0,   12'd0,    1'b0},
        '{llrb_pkg::MODE_STREAM,    llrb_pkg::CH_CR, 8'd0,   12'd0,    1'b0},  // cr dropped
        '{llrb_pkg::MODE_STREAM,    8'h62,           8'd0,   12'd0,    1'b0},
        '{llrb_pkg::MODE_STREAM,    llrb_pkg::CH_LF, 8'd0,   12'd0,    1'b0},  // commit "ab"
        '{llrb_pkg::MODE_READ,      8'h00,           8'd0,   12'd1,    1'b0},
        '{llrb_pkg::MODE_READ,      8'h00,           8'd0,   12'd4095, 1'b0},  // offset past end
        '{llrb_pkg::MODE_READ,      8'h00,           8'd255, 12'd0,    1'b0},  // index past count
        '{llrb_pkg::MODE_STREAM,    8'h78,           8'd0,   12'd0,    1'b0},
        '{llrb_pkg::MODE_MARK_BEG,  8'h00,           8'd0,   12'd0,    1'b0},  // flushes pending
        '{llrb_pkg::MODE_MARK_BYTE, llrb_pkg::CH_LF, 8'd0,   12'd0,    1'b0},  // raw newline
        '{llrb_pkg::MODE_MARK_BYTE, 8'h00,           8'd0,   12'd0,    1'b0},
        '{llrb_pkg::MODE_MARK_BYTE, 8'hFF,           8'd0,   12'd0,    1'b0},
        '{llrb_pkg::MODE_MARK_END,  8'h00,           8'd0,   12'd0,    1'b0},
        '{llrb_pkg::MODE_MARK_BEG,  8'h00,           8'd0,   12'd0,    1'b0},  // nothing to flush
        '{llrb_pkg::MODE_MARK_END,  8'h00,           8'd0,   12'd0,    1'b0},  // empty marker line
        '{llrb_pkg::MODE_READ,      8'h00,           8'd2,   12'd1,    1'b0},
        '{MODE_SPARE6,              8'hFF,           8'd0,   12'd0,    1'b0},
        '{MODE_SPARE7,              8'hFF,           8'hFF,  12'hFFF,  1'b0},
        '{llrb_pkg::MODE_STREAM,    llrb_pkg::CH_LF, 8'd0,   12'd0,    1'b0},  // empty stream line
        '{llrb_pkg::MODE_CLEAR,     8'h00,           8'd0,   12'd0,    1'b1},
        '{llrb_pkg::MODE_READ,      8'h00,           8'd0,   12'd0,    1'b1},
        '{llrb_pkg::MODE_MARK_BYTE, 8'h80,           8'd0,   12'd0,    1'b0},  // no mark start
        '{llrb_pkg::MODE_STREAM,    llrb_pkg::CH_LF, 8'd0,   12'd0,    1'b0}
    };

    // byte and line capacity per phase, out-of-range values included
    int unsigned phase_bcap [NUM_PHASES] = '{4096, 2, 40, 0, 8191, 100, 13, 600};
    int unsigned phase_lcap [NUM_PHASES] = '{256, 1, 4, 0, 511, 3, 300, 20};

    initial begin
        status_t zero;
        zero = '{default: '0};
        oldest = 0; held = 0; wr_ptr = 0; used_bytes = 0; pend_len = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            send_item(rows[i].mode, rows[i].data, rows[i].idx, rows[i].ofs,
                      rows[i].typed, zero);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(llrb_pkg::CFG_BYTE_CAP, 13'(phase_bcap[p]));
            write_reg(llrb_pkg::CFG_LINE_CAP, 13'(phase_lcap[p]));
            case (p % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 53; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 53; end
                default: begin send_pct = 10; recv_pct = 10; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
            wait_drained();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/llrb_pkg.sv
hw/rtl/llrb_front.sv
hw/rtl/llrb_queue.sv
hw/rtl/llrb_back.sv
hw/rtl/line_log_ring_buffer.sv
sim/line_log_ring_buffer_tb.sv
